[design/dpfts_pkg.sv]
package dpfts_pkg;

    localparam int CRIT_SLOTS_DEF = 4;
    localparam int NORM_SLOTS_DEF = 2;
    localparam int FRAME_MAX_DEF  = 256;

    localparam int REQ_W     = 3;
    localparam int LEN_W     = 9;
    localparam int SLOT_W    = 2;
    localparam int FREE_W    = 3;
    localparam int CNT32_W   = 32;

    localparam logic [CNT32_W-1:0] TIMEOUT_RESET = 32'd100;

    typedef enum logic [REQ_W-1:0] {
        REQ_SUBMIT  = 3'd0,
        REQ_DONE    = 3'd1,
        REQ_ERROR   = 3'd2,
        REQ_IDLE    = 3'd3,
        REQ_TICK    = 3'd4,
        REQ_DISCARD = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_LAUNCH
    } ctl_state_t;

    typedef struct packed {
        logic latch;
        logic apply;
        logic launch;
    } dp_cmd_t;

endpackage

[design/dpfts_ctrl.sv]
module dpfts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output dpfts_pkg::dp_cmd_t cmd
);
    import dpfts_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:  state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        cmd.latch  = 1'b0;
        cmd.apply  = 1'b0;
        cmd.launch = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            ST_APPLY:  cmd.apply  = 1'b1;
            ST_LAUNCH: cmd.launch = 1'b1;
            default:   busy       = 1'b1;
        endcase
    end

endmodule

[design/dpfts_dp.sv]
module dpfts_dp #(
    parameter int CRIT_SLOTS = dpfts_pkg::CRIT_SLOTS_DEF,
    parameter int NORM_SLOTS = dpfts_pkg::NORM_SLOTS_DEF,
    parameter int FRAME_MAX  = dpfts_pkg::FRAME_MAX_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpfts_pkg::dp_cmd_t                cmd,
    input  logic [dpfts_pkg::REQ_W-1:0]       req_type,
    input  logic                              critical,
    input  logic [dpfts_pkg::LEN_W-1:0]       frame_len,
    input  logic                              cfg_we,
    input  logic [dpfts_pkg::CNT32_W-1:0]     cfg_wdata,
    output logic                              done,
    output logic                              accepted,
    output logic [dpfts_pkg::SLOT_W-1:0]      fill_slot,
    output logic                              dropped_now,
    output logic                              start_valid,
    output logic                              start_from_critical,
    output logic [dpfts_pkg::SLOT_W-1:0]      start_slot,
    output logic [dpfts_pkg::LEN_W-1:0]       start_len,
    output logic                              all_idle,
    output logic [dpfts_pkg::FREE_W-1:0]      critical_free,
    output logic [dpfts_pkg::CNT32_W-1:0]     drop_total,
    output logic [dpfts_pkg::CNT32_W-1:0]     error_total
);
    import dpfts_pkg::*;

    localparam int CPW = (CRIT_SLOTS > 1) ? $clog2(CRIT_SLOTS) : 1;
    localparam int NPW = (NORM_SLOTS > 1) ? $clog2(NORM_SLOTS) : 1;
    localparam int CCW = $clog2(CRIT_SLOTS + 1);
    localparam int NCW = $clog2(NORM_SLOTS + 1);
    localparam logic [CPW-1:0] CRIT_LAST = CPW'(CRIT_SLOTS - 1);
    localparam logic [NPW-1:0] NORM_LAST = NPW'(NORM_SLOTS - 1);
    localparam logic [CCW-1:0] CRIT_FULL = CCW'(CRIT_SLOTS);
    localparam logic [NCW-1:0] NORM_FULL = NCW'(NORM_SLOTS);
    localparam logic [CNT32_W-1:0] LEN_LIMIT = CNT32_W'(FRAME_MAX);

    function automatic logic [CPW-1:0] crit_inc(input logic [CPW-1:0] p);
        crit_inc = (p == CRIT_LAST) ? '0 : p + CPW'(1);
    endfunction

    function automatic logic [NPW-1:0] norm_inc(input logic [NPW-1:0] p);
        norm_inc = (p == NORM_LAST) ? '0 : p + NPW'(1);
    endfunction

    logic [REQ_W-1:0]   req_reg;
    logic               crit_in_reg;
    logic [LEN_W-1:0]   len_in_reg;
    logic [CNT32_W-1:0] timeout_reg;

    logic [CPW-1:0] crit_head_reg, crit_head_next;
    logic [CPW-1:0] crit_tail_reg, crit_tail_next;
    logic [CCW-1:0] crit_count_reg, crit_count_next;
    logic [NPW-1:0] norm_head_reg, norm_head_next;
    logic [NPW-1:0] norm_tail_reg, norm_tail_next;
    logic [NCW-1:0] norm_count_reg, norm_count_next;
    logic sending_reg, sending_next;
    logic draining_reg, draining_next;
    logic active_crit_reg, active_crit_next;
    logic attempt_reg, attempt_next;
    logic [CNT32_W-1:0] elapsed_reg, elapsed_next;
    logic [CNT32_W-1:0] drop_cnt_reg, drop_cnt_next;
    logic [CNT32_W-1:0] err_cnt_reg, err_cnt_next;

    logic [LEN_W-1:0] crit_len_mem [CRIT_SLOTS];
    logic [LEN_W-1:0] norm_len_mem [NORM_SLOTS];
    logic             crit_wr_en;
    logic [CPW-1:0]   crit_wr_idx;
    logic             norm_wr_en;
    logic [NPW-1:0]   norm_wr_idx;

    logic               done_reg;
    logic               accepted_reg, accepted_next;
    logic [SLOT_W-1:0]  fill_slot_reg, fill_slot_next;
    logic               dropped_reg, dropped_next;
    logic               sv_reg, sv_next;
    logic               sfc_reg, sfc_next;
    logic [SLOT_W-1:0]  sslot_reg, sslot_next;
    logic [LEN_W-1:0]   slen_reg, slen_next;
    logic               all_idle_reg, all_idle_next;
    logic [FREE_W-1:0]  free_reg, free_next;

    logic               in_flight;
    logic [LEN_W-1:0]   launch_len;
    logic [SLOT_W-1:0]  launch_slot;
    logic [CNT32_W-1:0] elapsed_inc;
    logic [CCW-1:0]     crit_free_w;

    assign in_flight = sending_reg | draining_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg     <= req_type;
            crit_in_reg <= critical;
            len_in_reg  <= frame_len;
        end
        if (crit_wr_en)
        begin
            crit_len_mem[crit_wr_idx] <= len_in_reg;
        end
        if (norm_wr_en)
        begin
            norm_len_mem[norm_wr_idx] <= len_in_reg;
        end
        accepted_reg  <= accepted_next;
        fill_slot_reg <= fill_slot_next;
        dropped_reg   <= dropped_next;
        sv_reg        <= sv_next;
        sfc_reg       <= sfc_next;
        sslot_reg     <= sslot_next;
        slen_reg      <= slen_next;
        all_idle_reg  <= all_idle_next;
        free_reg      <= free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            crit_head_reg   <= '0;
            crit_tail_reg   <= '0;
            crit_count_reg  <= '0;
            norm_head_reg   <= '0;
            norm_tail_reg   <= '0;
            norm_count_reg  <= '0;
            sending_reg     <= 1'b0;
            draining_reg    <= 1'b0;
            active_crit_reg <= 1'b0;
            attempt_reg     <= 1'b0;
            elapsed_reg     <= '0;
            drop_cnt_reg    <= '0;
            err_cnt_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            crit_head_reg   <= crit_head_next;
            crit_tail_reg   <= crit_tail_next;
            crit_count_reg  <= crit_count_next;
            norm_head_reg   <= norm_head_next;
            norm_tail_reg   <= norm_tail_next;
            norm_count_reg  <= norm_count_next;
            sending_reg     <= sending_next;
            draining_reg    <= draining_next;
            active_crit_reg <= active_crit_next;
            attempt_reg     <= attempt_next;
            elapsed_reg     <= elapsed_next;
            drop_cnt_reg    <= drop_cnt_next;
            err_cnt_reg     <= err_cnt_next;
            done_reg        <= cmd.launch;
        end
    end

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + CNT32_W'(1);

    always_comb
    begin
        crit_head_next   = crit_head_reg;
        crit_tail_next   = crit_tail_reg;
        crit_count_next  = crit_count_reg;
        norm_head_next   = norm_head_reg;
        norm_tail_next   = norm_tail_reg;
        norm_count_next  = norm_count_reg;
        sending_next     = sending_reg;
        draining_next    = draining_reg;
        active_crit_next = active_crit_reg;
        attempt_next     = attempt_reg;
        elapsed_next     = elapsed_reg;
        drop_cnt_next    = drop_cnt_reg;
        err_cnt_next     = err_cnt_reg;
        crit_wr_en       = 1'b0;
        crit_wr_idx      = crit_head_reg;
        norm_wr_en       = 1'b0;
        norm_wr_idx      = norm_head_reg;
        accepted_next    = accepted_reg;
        fill_slot_next   = fill_slot_reg;
        dropped_next     = dropped_reg;
        sv_next          = sv_reg;
        sfc_next         = sfc_reg;
        sslot_next       = sslot_reg;
        slen_next        = slen_reg;
        all_idle_next    = all_idle_reg;
        free_next        = free_reg;
        launch_len       = '0;
        launch_slot      = '0;
        crit_free_w      = '0;

        if (cmd.apply)
        begin
            accepted_next  = 1'b0;
            fill_slot_next = '0;
            dropped_next   = 1'b0;
            attempt_next   = 1'b1;
            unique case (req_t'(req_reg))
                REQ_SUBMIT:
                begin
                    if (len_in_reg == '0 || CNT32_W'(len_in_reg) > LEN_LIMIT)
                    begin
                        attempt_next = 1'b0;
                    end
                    else if (crit_in_reg)
                    begin
                        if (crit_count_reg >= CRIT_FULL)
                        begin
                            drop_cnt_next = drop_cnt_reg + CNT32_W'(1);
                            dropped_next  = 1'b1;
                            attempt_next  = 1'b0;
                        end
                        else
                        begin
                            crit_wr_en      = 1'b1;
                            crit_wr_idx     = crit_head_reg;
                            crit_head_next  = crit_inc(crit_head_reg);
                            crit_count_next = crit_count_reg + CCW'(1);
                            accepted_next   = 1'b1;
                            fill_slot_next  = SLOT_W'(crit_head_reg);
                        end
                    end
                    else
                    begin
                        norm_wr_en = 1'b1;
                        if (norm_count_reg >= NORM_FULL)
                        begin
                            if (in_flight && !active_crit_reg)
                            begin
                                norm_wr_idx = norm_inc(norm_tail_reg);
                            end
                            else
                            begin
                                norm_wr_idx = (norm_head_reg == '0) ? NORM_LAST
                                              : norm_head_reg - NPW'(1);
                            end
                            drop_cnt_next = drop_cnt_reg + CNT32_W'(1);
                            dropped_next  = 1'b1;
                        end
                        else
                        begin
                            norm_wr_idx     = norm_head_reg;
                            norm_head_next  = norm_inc(norm_head_reg);
                            norm_count_next = norm_count_reg + NCW'(1);
                        end
                        accepted_next  = 1'b1;
                        fill_slot_next = SLOT_W'(norm_wr_idx);
                    end
                end
                REQ_DONE:
                begin
                    if (sending_reg)
                    begin
                        sending_next  = 1'b0;
                        draining_next = 1'b1;
                    end
                end
                REQ_ERROR, REQ_IDLE, REQ_TICK:
                begin
                    // retire on error, line idle or timeout
                    if ((req_t'(req_reg) == REQ_ERROR && sending_reg) ||
                        (req_t'(req_reg) == REQ_IDLE && draining_reg) ||
                        (req_t'(req_reg) == REQ_TICK && in_flight &&
                         elapsed_inc > timeout_reg))
                    begin
                        sending_next  = 1'b0;
                        draining_next = 1'b0;
                        if (req_t'(req_reg) != REQ_IDLE)
                        begin
                            err_cnt_next = err_cnt_reg + CNT32_W'(1);
                        end
                        if (active_crit_reg)
                        begin
                            if (crit_count_reg != '0)
                            begin
                                crit_tail_next  = crit_inc(crit_tail_reg);
                                crit_count_next = crit_count_reg - CCW'(1);
                            end
                        end
                        else if (norm_count_reg != '0)
                        begin
                            norm_tail_next  = norm_inc(norm_tail_reg);
                            norm_count_next = norm_count_reg - NCW'(1);
                        end
                    end
                    if (req_t'(req_reg) == REQ_TICK && in_flight)
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                REQ_DISCARD:
                begin
                    if (!in_flight)
                    begin
                        crit_head_next  = '0;
                        crit_tail_next  = '0;
                        crit_count_next = '0;
                        norm_head_next  = '0;
                        norm_tail_next  = '0;
                        norm_count_next = '0;
                    end
                    else if (active_crit_reg)
                    begin
                        crit_count_next = (crit_count_reg != '0) ? CCW'(1) : '0;
                        crit_head_next  = (crit_count_reg != '0) ? crit_inc(crit_tail_reg)
                                                                 : crit_tail_reg;
                        norm_head_next  = '0;
                        norm_tail_next  = '0;
                        norm_count_next = '0;
                    end
                    else
                    begin
                        norm_count_next = (norm_count_reg != '0) ? NCW'(1) : '0;
                        norm_head_next  = (norm_count_reg != '0) ? norm_inc(norm_tail_reg)
                                                                 : norm_tail_reg;
                        crit_head_next  = '0;
                        crit_tail_next  = '0;
                        crit_count_next = '0;
                    end
                end
                default:
                begin
                    attempt_next = 1'b0;
                end
            endcase
        end

        if (cmd.launch)
        begin
            sv_next    = 1'b0;
            sfc_next   = 1'b0;
            sslot_next = '0;
            slen_next  = '0;
            if (attempt_reg && !in_flight &&
                (crit_count_reg != '0 || norm_count_reg != '0))
            begin
                if (crit_count_reg != '0)
                begin
                    active_crit_next = 1'b1;
                    launch_slot      = SLOT_W'(crit_tail_reg);
                    launch_len       = crit_len_mem[crit_tail_reg];
                end
                else
                begin
                    active_crit_next = 1'b0;
                    launch_slot      = SLOT_W'(norm_tail_reg);
                    launch_len       = norm_len_mem[norm_tail_reg];
                end
                if (launch_len != '0)
                begin
                    sending_next = 1'b1;
                    elapsed_next = '0;
                    sv_next      = 1'b1;
                    sfc_next     = active_crit_next;
                    sslot_next   = launch_slot;
                    slen_next    = launch_len;
                end
            end
            all_idle_next = !sending_next && !draining_reg &&
                            crit_count_reg == '0 && norm_count_reg == '0;
            crit_free_w   = CRIT_FULL - crit_count_reg;
            free_next     = FREE_W'(crit_free_w);
        end
    end

    assign done                = done_reg;
    assign accepted            = accepted_reg;
    assign fill_slot           = fill_slot_reg;
    assign dropped_now         = dropped_reg;
    assign start_valid         = sv_reg;
    assign start_from_critical = sfc_reg;
    assign start_slot          = sslot_reg;
    assign start_len           = slen_reg;
    assign all_idle            = all_idle_reg;
    assign critical_free       = free_reg;
    assign drop_total          = drop_cnt_reg;
    assign error_total         = err_cnt_reg;

endmodule

[design/dual_priority_frame_tx_scheduler_core.sv]
// Channel   Direction  Handshake                Payload
// request   in         start & !busy            req_type, critical, frame_len
// result    out        done (one cycle strobe)  accepted .. error_total
// config    in         cfg_we                   cfg_wdata (timeout in ticks)
//
// Each transaction runs through latch, state update and launch check, in that order.
// The controller sequences one transaction at a time through the datapath.
// done pulses the cycle after launch; busy is already low then.
// The receiver cannot stall; results are never held.
// rst_n is asynchronous; timeout resets to 100 ticks, rings come up empty.
module dual_priority_frame_tx_scheduler_core #(
    parameter int CRIT_SLOTS = dpfts_pkg::CRIT_SLOTS_DEF,
    parameter int NORM_SLOTS = dpfts_pkg::NORM_SLOTS_DEF,
    parameter int FRAME_MAX  = dpfts_pkg::FRAME_MAX_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dpfts_pkg::REQ_W-1:0]       req_type,
    input  logic                              critical,
    input  logic [dpfts_pkg::LEN_W-1:0]       frame_len,
    input  logic                              cfg_we,
    input  logic [dpfts_pkg::CNT32_W-1:0]     cfg_wdata,
    output logic                              done,
    output logic                              accepted,
    output logic [dpfts_pkg::SLOT_W-1:0]      fill_slot,
    output logic                              dropped_now,
    output logic                              start_valid,
    output logic                              start_from_critical,
    output logic [dpfts_pkg::SLOT_W-1:0]      start_slot,
    output logic [dpfts_pkg::LEN_W-1:0]       start_len,
    output logic                              all_idle,
    output logic [dpfts_pkg::FREE_W-1:0]      critical_free,
    output logic [dpfts_pkg::CNT32_W-1:0]     drop_total,
    output logic [dpfts_pkg::CNT32_W-1:0]     error_total
);
    import dpfts_pkg::*;

    dp_cmd_t cmd;

    dpfts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    dpfts_dp #(
        .CRIT_SLOTS (CRIT_SLOTS),
        .NORM_SLOTS (NORM_SLOTS),
        .FRAME_MAX  (FRAME_MAX)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .req_type            (req_type),
        .critical            (critical),
        .frame_len           (frame_len),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .done                (done),
        .accepted            (accepted),
        .fill_slot           (fill_slot),
        .dropped_now         (dropped_now),
        .start_valid         (start_valid),
        .start_from_critical (start_from_critical),
        .start_slot          (start_slot),
        .start_len           (start_len),
        .all_idle            (all_idle),
        .critical_free       (critical_free),
        .drop_total          (drop_total),
        .error_total         (error_total)
    );

endmodule

[design/dpfts_checker.sv]
module dpfts_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic                              accepted,
    input logic [dpfts_pkg::SLOT_W-1:0]      fill_slot,
    input logic                              start_valid,
    input logic                              start_from_critical,
    input logic [dpfts_pkg::SLOT_W-1:0]      start_slot,
    input logic [dpfts_pkg::LEN_W-1:0]       start_len,
    input logic                              all_idle
);
    import dpfts_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> fill_slot == '0)
        else $error("fill_slot nonzero on rejected submit");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start_valid |-> start_len == '0 && start_slot == '0 && !start_from_critical)
        else $error("start fields nonzero without start");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && start_valid |-> !all_idle && start_len != '0)
        else $error("started frame reported idle or empty");

endmodule

bind dual_priority_frame_tx_scheduler_core dpfts_checker u_dpfts_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .done                (done),
    .accepted            (accepted),
    .fill_slot           (fill_slot),
    .start_valid         (start_valid),
    .start_from_critical (start_from_critical),
    .start_slot          (start_slot),
    .start_len           (start_len),
    .all_idle            (all_idle)
);

[tb/sv/dpfts_result_checker.sv]
`timescale 1ns / 100ps

module dpfts_result_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [dpfts_pkg::REQ_W-1:0]      req_type,
    input  logic                             critical,
    input  logic [dpfts_pkg::LEN_W-1:0]      frame_len,
    input  logic                             cfg_we,
    input  logic [dpfts_pkg::CNT32_W-1:0]    cfg_wdata,
    input  logic                             done,
    input  logic                             accepted,
    input  logic [dpfts_pkg::SLOT_W-1:0]     fill_slot,
    input  logic                             dropped_now,
    input  logic                             start_valid,
    input  logic                             start_from_critical,
    input  logic [dpfts_pkg::SLOT_W-1:0]     start_slot,
    input  logic [dpfts_pkg::LEN_W-1:0]      start_len,
    input  logic                             all_idle,
    input  logic [dpfts_pkg::FREE_W-1:0]     critical_free,
    input  logic [dpfts_pkg::CNT32_W-1:0]    drop_total,
    input  logic [dpfts_pkg::CNT32_W-1:0]    error_total,
    output int unsigned                      fail_count,
    output int unsigned                      pending,
    output int unsigned                      compared
);
    import dpfts_pkg::*;

    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   fill_slot;
        logic                dropped_now;
        logic                start_valid;
        logic                start_from_critical;
        logic [SLOT_W-1:0]   start_slot;
        logic [LEN_W-1:0]    start_len;
        logic                all_idle;
        logic [FREE_W-1:0]   critical_free;
        logic [CNT32_W-1:0]  drop_total;
        logic [CNT32_W-1:0]  error_total;
    } sched_result_t;

    sched_result_t results_due[$];

    // scheduler shadow state
    logic [1:0]          crit_wr;
    logic [1:0]          crit_rd;
    logic [2:0]          crit_used;
    logic                norm_wr;
    logic                norm_rd;
    logic [1:0]          norm_used;
    logic                tx_sending;
    logic                tx_draining;
    logic                tx_crit;
    logic [LEN_W-1:0]    crit_len_mem [CRIT_SLOTS_DEF];
    logic [LEN_W-1:0]    norm_len_mem [NORM_SLOTS_DEF];
    logic [CNT32_W-1:0]  tick_age;
    logic [CNT32_W-1:0]  drops;
    logic [CNT32_W-1:0]  errors;
    logic [CNT32_W-1:0]  timeout_limit;

    function automatic void reset_model();
        crit_wr       = '0;
        crit_rd       = '0;
        crit_used     = '0;
        norm_wr       = '0;
        norm_rd       = '0;
        norm_used     = '0;
        tx_sending    = 1'b0;
        tx_draining   = 1'b0;
        tx_crit       = 1'b0;
        tick_age      = '0;
        drops         = '0;
        errors        = '0;
        timeout_limit = TIMEOUT_RESET;
        foreach (crit_len_mem[i]) crit_len_mem[i] = '0;
        foreach (norm_len_mem[i]) norm_len_mem[i] = '0;
    endfunction

    function automatic void retire_frame();
        if (tx_crit)
        begin
            if (crit_used != 0)
            begin
                crit_rd++;
                crit_used--;
            end
        end
        else if (norm_used != 0)
        begin
            norm_rd++;
            norm_used--;
        end
    endfunction

    function automatic void abort_frame();
        tx_sending  = 1'b0;
        tx_draining = 1'b0;
        errors++;
        retire_frame();
    endfunction

    function automatic void launch_next(inout sched_result_t r);
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] slot;
        if (tx_sending || tx_draining)
            return;
        if (crit_used != 0)
        begin
            tx_crit = 1'b1;
            slot    = crit_rd;
            len     = crit_len_mem[crit_rd];
        end
        else if (norm_used != 0)
        begin
            tx_crit = 1'b0;
            slot    = {1'b0, norm_rd};
            len     = norm_len_mem[norm_rd];
        end
        else
            return;
        // a zero length at the ring front never launches
        if (len == 0)
            return;
        tx_sending            = 1'b1;
        tick_age              = '0;
        r.start_valid         = 1'b1;
        r.start_from_critical = tx_crit;
        r.start_slot          = slot;
        r.start_len           = len;
    endfunction

    function automatic sched_result_t predict_result(input logic [REQ_W-1:0] req,
                                                     input logic crit,
                                                     input logic [LEN_W-1:0] len);
        sched_result_t r;
        logic          launch;
        logic          nslot;
        r      = '0;
        launch = 1'b1;
        case (req)
            REQ_SUBMIT:
            begin
                if (len == 0 || len > FRAME_MAX_DEF)
                    launch = 1'b0;
                else if (crit)
                begin
                    if (crit_used >= CRIT_SLOTS_DEF)
                    begin
                        drops++;
                        r.dropped_now = 1'b1;
                        launch        = 1'b0;
                    end
                    else
                    begin
                        crit_len_mem[crit_wr] = len;
                        r.accepted            = 1'b1;
                        r.fill_slot           = crit_wr;
                        crit_wr++;
                        crit_used++;
                    end
                end
                else
                begin
                    if (norm_used >= NORM_SLOTS_DEF)
                    begin
                        // full: overwrite newest, or the one after an in-flight normal frame
                        nslot = norm_wr - 1'b1;
                        if ((tx_sending || tx_draining) && !tx_crit)
                            nslot = norm_rd + 1'b1;
                        drops++;
                        r.dropped_now = 1'b1;
                    end
                    else
                    begin
                        nslot = norm_wr;
                        norm_wr++;
                        norm_used++;
                    end
                    norm_len_mem[nslot] = len;
                    r.accepted          = 1'b1;
                    r.fill_slot         = {1'b0, nslot};
                end
            end
            REQ_DONE:
            begin
                if (tx_sending)
                begin
                    tx_sending  = 1'b0;
                    tx_draining = 1'b1;
                end
            end
            REQ_ERROR:
            begin
                if (tx_sending)
                    abort_frame();
            end
            REQ_IDLE:
            begin
                if (tx_draining)
                begin
                    tx_draining = 1'b0;
                    retire_frame();
                end
            end
            REQ_TICK:
            begin
                if (tx_sending || tx_draining)
                begin
                    if (tick_age != '1)
                        tick_age++;
                    if (tick_age > timeout_limit)
                        abort_frame();
                end
            end
            REQ_DISCARD:
            begin
                if (!(tx_sending || tx_draining))
                begin
                    crit_wr = '0; crit_rd = '0; crit_used = '0;
                    norm_wr = '0; norm_rd = '0; norm_used = '0;
                end
                else if (tx_crit)
                begin
                    crit_used = (crit_used != 0) ? 3'd1 : 3'd0;
                    crit_wr   = crit_rd + crit_used[1:0];
                    norm_wr = '0; norm_rd = '0; norm_used = '0;
                end
                else
                begin
                    norm_used = (norm_used != 0) ? 2'd1 : 2'd0;
                    norm_wr   = norm_rd + norm_used[0];
                    crit_wr = '0; crit_rd = '0; crit_used = '0;
                end
            end
            default:
                launch = 1'b0;
        endcase

        if (launch)
            launch_next(r);

        r.all_idle      = !tx_sending && !tx_draining && crit_used == 0 && norm_used == 0;
        r.critical_free = FREE_W'(CRIT_SLOTS_DEF - crit_used);
        r.drop_total    = drops;
        r.error_total   = errors;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            reset_model();
            results_due.delete();
        end
        else
        begin
            // the result of an earlier transaction may land on the edge that accepts the next
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result strobe with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(accepted));
                    check_field("fill_slot", 32'(want.fill_slot), 32'(fill_slot));
                    check_field("dropped_now", 32'(want.dropped_now), 32'(dropped_now));
                    check_field("start_valid", 32'(want.start_valid), 32'(start_valid));
                    check_field("start_from_critical", 32'(want.start_from_critical),
                                32'(start_from_critical));
                    check_field("start_slot", 32'(want.start_slot), 32'(start_slot));
                    check_field("start_len", 32'(want.start_len), 32'(start_len));
                    check_field("all_idle", 32'(want.all_idle), 32'(all_idle));
                    check_field("critical_free", 32'(want.critical_free),
                                32'(critical_free));
                    check_field("drop_total", want.drop_total, drop_total);
                    check_field("error_total", want.error_total, error_total);
                    compared++;
                end
            end
            if (cfg_we)
                timeout_limit = cfg_wdata;
            if (start && !busy)
                results_due.push_back(predict_result(req_type, critical, frame_len));
        end
        pending = results_due.size();
    end

endmodule

[tb/sv/tb_dual_priority_frame_tx_scheduler_core.sv]
`timescale 1ns / 100ps

module tb_dual_priority_frame_tx_scheduler_core;
    import dpfts_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 215;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [REQ_W-1:0]    req_type = '0;
    logic                critical = 1'b0;
    logic [LEN_W-1:0]    frame_len = '0;
    logic                cfg_we = 1'b0;
    logic [CNT32_W-1:0]  cfg_wdata = '0;

    logic                busy;
    logic                done;
    logic                accepted;
    logic [SLOT_W-1:0]   fill_slot;
    logic                dropped_now;
    logic                start_valid;
    logic                start_from_critical;
    logic [SLOT_W-1:0]   start_slot;
    logic [LEN_W-1:0]    start_len;
    logic                all_idle;
    logic [FREE_W-1:0]   critical_free;
    logic [CNT32_W-1:0]  drop_total;
    logic [CNT32_W-1:0]  error_total;

    int unsigned         fail_count;
    int unsigned         pending;
    int unsigned         compared;
    int unsigned         n_sent = 0;
    int unsigned         n_settings = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dual_priority_frame_tx_scheduler_core i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .req_type            (req_type),
        .critical            (critical),
        .frame_len           (frame_len),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .done                (done),
        .accepted            (accepted),
        .fill_slot           (fill_slot),
        .dropped_now         (dropped_now),
        .start_valid         (start_valid),
        .start_from_critical (start_from_critical),
        .start_slot          (start_slot),
        .start_len           (start_len),
        .all_idle            (all_idle),
        .critical_free       (critical_free),
        .drop_total          (drop_total),
        .error_total         (error_total)
    );

    dpfts_result_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .req_type            (req_type),
        .critical            (critical),
        .frame_len           (frame_len),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .done                (done),
        .accepted            (accepted),
        .fill_slot           (fill_slot),
        .dropped_now         (dropped_now),
        .start_valid         (start_valid),
        .start_from_critical (start_from_critical),
        .start_slot          (start_slot),
        .start_len           (start_len),
        .all_idle            (all_idle),
        .critical_free       (critical_free),
        .drop_total          (drop_total),
        .error_total         (error_total),
        .fail_count          (fail_count),
        .pending             (pending),
        .compared            (compared)
    );

    // start stays high across back-to-back transactions
    task automatic send_item(input logic [REQ_W-1:0] rq, input logic crit,
                             input logic [LEN_W-1:0] len);
        start     <= 1'b1;
        req_type  <= rq;
        critical  <= crit;
        frame_len <= len;
        do
            @(posedge clk);
        while (busy);
        n_sent++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results(input int unsigned settle);
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [CNT32_W-1:0] value);
        drain_results(6);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    task automatic send_random_item(output bit counted);
        int unsigned      pick;
        int unsigned      len_pick;
        logic [LEN_W-1:0] len;
        logic             crit;
        logic [LEN_W-1:0] any_len;
        pick     = $urandom_range(0, 99);
        len_pick = $urandom_range(0, 19);
        crit     = 1'($urandom_range(0, 1));
        any_len  = LEN_W'($urandom_range(0, 511));
        counted  = 1'b1;
        if (len_pick == 0)
            len = '0;
        else if (len_pick == 1)
            len = LEN_W'($urandom_range(FRAME_MAX_DEF + 1, 511));
        else if (len_pick == 2)
            len = LEN_W'(FRAME_MAX_DEF);
        else
            len = LEN_W'($urandom_range(1, FRAME_MAX_DEF));
        if (pick < 36)
            send_item(REQ_SUBMIT, crit, len);
        else if (pick < 52)
            send_item(REQ_DONE, crit, any_len);
        else if (pick < 66)
            send_item(REQ_IDLE, crit, any_len);
        else if (pick < 73)
            send_item(REQ_ERROR, crit, any_len);
        else if (pick < 93)
            send_item(REQ_TICK, crit, any_len);
        else if (pick < 97)
            send_item(REQ_DISCARD, crit, any_len);
        else
        begin
            send_item($urandom_range(0, 1) ? REQ_RSVD_7 : REQ_RSVD_6, crit, any_len);
            counted = 1'b0;
        end
    endtask

    initial
    begin
        logic [CNT32_W-1:0] phase_timeout [PHASES];
        int unsigned        phase_items;
        bit                 counted;

        phase_timeout[0] = 32'd1;
        phase_timeout[1] = 32'hFFFF_FFFF;
        phase_timeout[2] = 32'd3;
        phase_timeout[3] = $urandom_range(4, 12);
        phase_timeout[4] = 32'd2;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rejections and wrong-phase events on an empty scheduler
        send_item(REQ_SUBMIT, 1'b0, 9'd0);
        send_item(REQ_SUBMIT, 1'b1, 9'd511);
        send_item(REQ_SUBMIT, 1'b1, LEN_W'(FRAME_MAX_DEF + 1));
        send_item(REQ_RSVD_6, 1'b1, 9'd511);
        send_item(REQ_RSVD_7, 1'b0, 9'd0);
        send_item(REQ_DONE, 1'b0, 9'd0);
        send_item(REQ_IDLE, 1'b0, 9'd0);
        send_item(REQ_TICK, 1'b0, 9'd0);
        send_item(REQ_DISCARD, 1'b0, 9'd0);
        // fill the critical ring past full
        send_item(REQ_SUBMIT, 1'b1, LEN_W'(FRAME_MAX_DEF));
        send_item(REQ_SUBMIT, 1'b1, 9'd1);
        send_item(REQ_SUBMIT, 1'b1, 9'h0AA);
        send_item(REQ_SUBMIT, 1'b1, 9'h055);
        send_item(REQ_SUBMIT, 1'b1, 9'd100);
        // normal ring overwrite of newest
        send_item(REQ_SUBMIT, 1'b0, 9'd1);
        send_item(REQ_SUBMIT, 1'b0, 9'd200);
        send_item(REQ_SUBMIT, 1'b0, 9'd77);
        send_item(REQ_IDLE, 1'b0, 9'd0);
        send_item(REQ_DONE, 1'b0, 9'd0);
        send_item(REQ_ERROR, 1'b0, 9'd0);
        send_item(REQ_IDLE, 1'b0, 9'd0);
        send_item(REQ_ERROR, 1'b0, 9'd0);
        send_item(REQ_DISCARD, 1'b0, 9'd0);
        send_item(REQ_TICK, 1'b0, 9'd0);
        send_item(REQ_DONE, 1'b0, 9'd0);
        send_item(REQ_IDLE, 1'b0, 9'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_timeout(phase_timeout[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (p < PHASES - 1 && $urandom_range(0, 5) == 0)
                    pause_sender($urandom_range(1, 16));
                send_random_item(counted);
                if (counted)
                    phase_items++;
            end
        end

        drain_results(8);
        $display("Summary: %0d transactions over %0d timeout settings, %0d results compared",
                 n_sent, n_settings, compared);
        $display("Summary: final drop count %0d, error/timeout count %0d",
                 drop_total, error_total);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
design/dpfts_pkg.sv
design/dpfts_ctrl.sv
design/dpfts_dp.sv
design/dual_priority_frame_tx_scheduler_core.sv
design/dpfts_checker.sv
tb/sv/dpfts_result_checker.sv
tb/sv/tb_dual_priority_frame_tx_scheduler_core.sv
